// ===== rtl/polc_pkg.sv =====
// Package for the PIR occupancy light controller.
// Holds codes, widths and reset constants shared by the interfaces and the top level.
// No dependencies.
package polc_pkg;

  // Field and state widths
  localparam int unsigned ModeW    = 2;
  localparam int unsigned ReasonW  = 2;
  localparam int unsigned HoldW    = 8;
  localparam int unsigned StripW   = 2;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned AbsW     = 14;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Timing constants
  localparam int unsigned SecsPerMin = 60;

  // Register reset values
  localparam logic [HoldW-1:0]   HoldReset   = 8'd20;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd600;

  // Input item kinds; the unused code is ignored
  typedef enum logic [ModeW-1:0] {
    MODE_TICK   = 2'd0,
    MODE_PIR    = 2'd1,
    MODE_STATUS = 2'd2
  } mode_e;

  // Report reasons
  typedef enum logic [ReasonW-1:0] {
    REASON_PERIODIC  = 2'd0,
    REASON_OCCUPANCY = 2'd1,
    REASON_REQUEST   = 2'd2
  } reason_e;

  // Relay modes; the unused code acts as forced off
  typedef enum logic [StripW-1:0] {
    STRIP_OFF  = 2'd0,
    STRIP_ON   = 2'd1,
    STRIP_AUTO = 2'd2
  } strip_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HOLD   = 2'd0,
    CFG_STRIP  = 2'd1,
    CFG_PERIOD = 2'd2
  } cfg_idx_e;

endpackage

// ===== rtl/polc_intf.sv =====
// Valid/ready channel interfaces for the PIR occupancy light controller.
// Input item, result item and configuration write channels.
// Depends on polc_pkg for field widths.
interface polc_in_if;
  logic                        valid;
  logic                        ready;
  logic [polc_pkg::ModeW-1:0]  mode;
  logic                        pir_level;

  modport source (output valid, output mode, output pir_level, input ready);
  modport sink   (input valid, input mode, input pir_level, output ready);
endinterface

interface polc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          relay_on;
  logic                          occupied;
  logic                          report_valid;
  logic [polc_pkg::ReasonW-1:0]  report_reason;
  logic                          pir_now;

  modport source (output valid, output relay_on, output occupied, output report_valid,
                  output report_reason, output pir_now, input ready);
  modport sink   (input valid, input relay_on, input occupied, input report_valid,
                  input report_reason, input pir_now, output ready);
endinterface

interface polc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [polc_pkg::CfgIdxW-1:0]   index;
  logic [polc_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pir_occupancy_light_control_unit.sv =====
// PIR occupancy light controller: an input beat passes through the input register, then
// the result register; throughput one item per cycle while the result channel is not
// stalled, set by the single pass of occupancy and timer logic between the registers.
// Reset (rst_ni low, asynchronous) clears all occupancy state and timers and loads
// hold 20 min, relay forced off, report period 600 s. Config writes are always accepted.
// Depends on polc_pkg and the channel interfaces in polc_intf.sv.
module pir_occupancy_light_control_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  polc_in_if.sink       in_i,
  polc_out_if.source    out_o,
  polc_cfg_if.sink      cfg_i
);

  // Configuration registers
  logic [polc_pkg::HoldW-1:0]   hold_minutes_q;
  polc_pkg::strip_e             strip_mode_q;
  logic [polc_pkg::PeriodW-1:0] report_period_q;

  // Occupancy state
  logic                         last_pir_q, last_pir_d;
  logic                         present_q, present_d;
  logic                         abs_counting_q, abs_counting_d;
  logic [polc_pkg::AbsW-1:0]    abs_seconds_q, abs_seconds_d;
  logic [polc_pkg::PeriodW-1:0] rpt_seconds_q, rpt_seconds_d;

  // Input stage
  logic                         s1_valid_q;
  logic [polc_pkg::ModeW-1:0]   s1_mode_q;
  logic                         s1_pir_q;
  logic                         s1_adv;

  // Result stage
  logic                         out_valid_q;
  logic                         out_relay_q, out_relay_d;
  logic                         out_occ_q;
  logic                         out_rpt_q, out_rpt_d;
  polc_pkg::reason_e            out_reason_q, out_reason_d;
  logic                         out_pir_q;

  logic [polc_pkg::AbsW-1:0]    hold_thr;
  logic [polc_pkg::AbsW-1:0]    abs_inc;
  logic [polc_pkg::PeriodW-1:0] rpt_inc;
  logic                         periodic;
  logic                         occ_evt;

  // Configuration writes, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_minutes_q  <= polc_pkg::HoldReset;
      strip_mode_q    <= polc_pkg::STRIP_OFF;
      report_period_q <= polc_pkg::PeriodReset;
    end else if (cfg_i.valid) begin
      case (polc_pkg::cfg_idx_e'(cfg_i.index))
        polc_pkg::CFG_HOLD:   hold_minutes_q  <= cfg_i.data[polc_pkg::HoldW-1:0];
        polc_pkg::CFG_STRIP:  strip_mode_q    <= polc_pkg::strip_e'(cfg_i.data[polc_pkg::StripW-1:0]);
        polc_pkg::CFG_PERIOD: report_period_q <= cfg_i.data[polc_pkg::PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the input stage when the result register is free or drains
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_mode_q <= in_i.mode;
      s1_pir_q  <= in_i.pir_level;
    end
  end

  // Hold threshold in seconds; fits in 14 bits for any 8-bit minute count
  assign hold_thr = polc_pkg::AbsW'(hold_minutes_q) * polc_pkg::AbsW'(polc_pkg::SecsPerMin);
  assign abs_inc  = abs_seconds_q + polc_pkg::AbsW'(1);
  assign rpt_inc  = rpt_seconds_q + polc_pkg::PeriodW'(1);

  // Occupancy, timers and report for the item in the input stage
  always_comb begin
    last_pir_d     = last_pir_q;
    present_d      = present_q;
    abs_counting_d = abs_counting_q;
    abs_seconds_d  = abs_seconds_q;
    rpt_seconds_d  = rpt_seconds_q;
    out_rpt_d      = 1'b0;
    out_reason_d   = polc_pkg::REASON_PERIODIC;
    periodic       = 1'b0;
    occ_evt        = 1'b0;
    if (s1_adv) begin
      case (polc_pkg::mode_e'(s1_mode_q))
        polc_pkg::MODE_TICK: begin
          periodic      = (rpt_inc == report_period_q);
          rpt_seconds_d = periodic ? '0 : rpt_inc;
          if (abs_counting_q) begin
            if (abs_inc >= hold_thr) begin
              abs_counting_d = 1'b0;
              abs_seconds_d  = '0;
              present_d      = 1'b0;
              occ_evt        = 1'b1;
            end else begin
              abs_seconds_d = abs_inc;
            end
          end
          // Occupancy report outranks the periodic one
          if (occ_evt) begin
            out_rpt_d     = 1'b1;
            out_reason_d  = polc_pkg::REASON_OCCUPANCY;
            rpt_seconds_d = '0;
          end else if (periodic) begin
            out_rpt_d    = 1'b1;
            out_reason_d = polc_pkg::REASON_PERIODIC;
          end
        end
        polc_pkg::MODE_PIR: begin
          if (s1_pir_q != last_pir_q) begin
            abs_seconds_d = '0;
            last_pir_d    = s1_pir_q;
            if (s1_pir_q) begin
              abs_counting_d = 1'b0;
              if (!present_q) begin
                present_d     = 1'b1;
                out_rpt_d     = 1'b1;
                out_reason_d  = polc_pkg::REASON_OCCUPANCY;
                rpt_seconds_d = '0;
              end
            end else begin
              abs_counting_d = 1'b1;
            end
          end
        end
        polc_pkg::MODE_STATUS: begin
          out_rpt_d     = 1'b1;
          out_reason_d  = polc_pkg::REASON_REQUEST;
          rpt_seconds_d = '0;
        end
        default: ;
      endcase
    end
  end

  // Relay drive from mode and occupancy after this item
  always_comb begin
    case (strip_mode_q)
      polc_pkg::STRIP_ON:   out_relay_d = 1'b1;
      polc_pkg::STRIP_AUTO: out_relay_d = present_d;
      default:              out_relay_d = 1'b0;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pir_q     <= 1'b0;
      present_q      <= 1'b0;
      abs_counting_q <= 1'b0;
      abs_seconds_q  <= '0;
      rpt_seconds_q  <= '0;
    end else begin
      last_pir_q     <= last_pir_d;
      present_q      <= present_d;
      abs_counting_q <= abs_counting_d;
      abs_seconds_q  <= abs_seconds_d;
      rpt_seconds_q  <= rpt_seconds_d;
    end
  end

  // Result register: load on advance, drop once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_relay_q  <= out_relay_d;
      out_occ_q    <= present_d;
      out_rpt_q    <= out_rpt_d;
      out_reason_q <= out_reason_d;
      out_pir_q    <= last_pir_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.relay_on      = out_relay_q;
  assign out_o.occupied      = out_occ_q;
  assign out_o.report_valid  = out_rpt_q;
  assign out_o.report_reason = out_reason_q;
  assign out_o.pir_now       = out_pir_q;

`ifndef ASSERT_OFF
  // Absence seconds only accumulate while the absence count runs
  a_abs_only_counting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (abs_seconds_q != '0) |-> abs_counting_q)
    else $error("absence seconds nonzero while not counting");

  // The room empties only on a tick
  a_empty_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(present_q) |-> ($past(s1_adv) && $past(s1_mode_q) == polc_pkg::MODE_TICK))
    else $error("occupancy dropped outside a tick");

  // The room fills only on a rising PIR sample
  a_fill_on_pir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(present_q) |-> ($past(s1_adv) && $past(s1_mode_q) == polc_pkg::MODE_PIR
                          && $past(s1_pir_q)))
    else $error("occupancy set without a rising PIR sample");

  // A beat with no report carries the zero reason code
  a_reason_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_rpt_q) |-> (out_reason_q == polc_pkg::REASON_PERIODIC))
    else $error("reason set without a report");
`endif

endmodule
